>>> rtl/ovl_pkg.sv
// ----------------------------------------------------------------------------
// ovl_pkg
// Shared types and codes for the ordered value list: command and status
// codes, field widths, and the control/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package ovl_pkg;

  // Field widths of the stream payloads.
  localparam int CMD_W  = 2;
  localparam int DATA_W = 32;
  localparam int POS_W  = 5;
  localparam int ST_W   = 2;

  // Output tdata: item_value, position, status, padded to whole bytes.
  localparam int OUT_FIELDS_W = DATA_W + POS_W + ST_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Command codes carried on the input tuser.
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

  // Status codes of a result.
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd3;

  // Which kind of result the datapath builds into the output register.
  typedef enum logic [1:0] {
    EMIT_NONE   = 2'd0,
    EMIT_APPEND = 2'd1,
    EMIT_DELETE = 2'd2,
    EMIT_DUMP   = 2'd3
  } emit_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load_in;   // capture the accepted command and value
    logic      scan_clr;  // restart the scan index and read entry zero
    logic      scan_inc;  // advance the scan index and read the next entry
    logic      srch_step; // compare the read entry, or shift it down after a match
    emit_sel_t emit;      // load a result into the output register
  } ovl_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;       // latched command
    logic             cnt_zero;  // list holds no entries
    logic             scan_last; // scan index is at the tail entry
    logic             out_free;  // output register can take a result
  } ovl_stat_t;

endpackage

>>> rtl/ovl_ram.sv
// ----------------------------------------------------------------------------
// ovl_ram
// Generic single-write, single-read RAM with a registered read port. The
// read data holds its value while no read is requested.
// ----------------------------------------------------------------------------
module ovl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/ovl_datapath.sv
// ----------------------------------------------------------------------------
// ovl_datapath
// Entry storage, fill count, scan index, match search with in-place
// compaction, and the output register of the ordered value list.
// ----------------------------------------------------------------------------
module ovl_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ovl_pkg::ovl_ctrl_t           ctrl,
  output ovl_pkg::ovl_stat_t           stat,
  input  logic [ovl_pkg::CMD_W-1:0]    in_cmd,
  input  logic [ovl_pkg::DATA_W-1:0]   in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ovl_pkg::DATA_W-1:0]   out_value,
  output logic [ovl_pkg::POS_W-1:0]    out_pos,
  output logic [ovl_pkg::ST_W-1:0]     out_status,
  output logic                         out_last
);
  import ovl_pkg::*;

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PW    = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CMD_W-1:0]  cmd;
  logic [DATA_W-1:0] value;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [AW-1:0]     scan;
  logic [AW-1:0]     hit;
  logic              found;
  logic [CNT_W-1:0]  scan_plus;
  logic [PW-1:0]     scan_pos;
  logic [PW-1:0]     hit_pos;
  logic [PW-1:0]     tail_pos;
  logic              cnt_full;
  logic              match;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  ovl_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Derived positions and flags.
  assign scan_plus = CNT_W'(scan) + 1'b1;
  assign scan_pos  = PW'(scan_plus);
  assign hit_pos   = PW'(CNT_W'(hit) + 1'b1);
  assign tail_pos  = PW'(count) + 1'b1;
  assign cnt_full  = (count == CNT_W'(DEPTH));
  assign match     = (ram_rdata == value);

  assign stat.cmd       = cmd;
  assign stat.cnt_zero  = (count == '0);
  assign stat.scan_last = (scan_plus == count);
  assign stat.out_free  = !out_valid || out_ready;

  // Capture of the accepted command.
  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      cmd   <= in_cmd;
      value <= in_value;
    end
  end

  // Scan index over the stored entries.
  always_ff @(posedge clk) begin
    if (ctrl.scan_clr) begin
      scan <= '0;
    end else if (ctrl.scan_inc) begin
      scan <= scan + 1'b1;
    end
  end

  // Match tracking during a delete search.
  always_ff @(posedge clk) begin
    if (rst || ctrl.load_in) begin
      found <= 1'b0;
    end else if (ctrl.srch_step && !found && match) begin
      found <= 1'b1;
      hit   <= scan;
    end
  end

  // Storage access: append writes at the tail, a search shifts later
  // entries down by one slot after the match.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = value;
    if (ctrl.emit == EMIT_APPEND && !cnt_full) begin
      ram_we = 1'b1;
    end else if (ctrl.srch_step && found) begin
      ram_we    = 1'b1;
      ram_waddr = scan - 1'b1;
      ram_wdata = ram_rdata;
    end
    ram_re    = ctrl.scan_clr || ctrl.scan_inc;
    ram_raddr = ctrl.scan_clr ? '0 : scan + 1'b1;
  end

  // Fill count update.
  always_comb begin
    count_next = count;
    if (ctrl.emit == EMIT_APPEND && !cnt_full) begin
      count_next = count + 1'b1;
    end else if (ctrl.emit == EMIT_DELETE && found && count != '0) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Output register: valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit != EMIT_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: result fields.
  always_ff @(posedge clk) begin
    case (ctrl.emit)
      EMIT_APPEND: begin
        out_value <= value;
        out_last  <= 1'b1;
        if (cnt_full) begin
          out_pos    <= '0;
          out_status <= ST_FULL;
        end else begin
          out_pos    <= tail_pos[POS_W-1:0];
          out_status <= ST_OK;
        end
      end
      EMIT_DELETE: begin
        out_value <= value;
        out_last  <= 1'b1;
        if (count == '0) begin
          out_pos    <= '0;
          out_status <= ST_EMPTY;
        end else if (found) begin
          out_pos    <= hit_pos[POS_W-1:0];
          out_status <= ST_OK;
        end else begin
          out_pos    <= '0;
          out_status <= ST_NOTFOUND;
        end
      end
      EMIT_DUMP: begin
        if (count == '0) begin
          out_value  <= '0;
          out_pos    <= '0;
          out_status <= ST_EMPTY;
          out_last   <= 1'b1;
        end else begin
          out_value  <= ram_rdata;
          out_pos    <= scan_pos[POS_W-1:0];
          out_status <= ST_OK;
          out_last   <= (scan_plus == count);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/ovl_ctrl.sv
// ----------------------------------------------------------------------------
// ovl_ctrl
// Controller of the ordered value list: accepts one command, sequences the
// search or dump over the stored entries and paces results into the output
// register.
// ----------------------------------------------------------------------------
module ovl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ovl_pkg::ovl_stat_t stat,
  output ovl_pkg::ovl_ctrl_t ctrl
);
  import ovl_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_SEARCH   = 5'b00100,
    S_DEL_DONE = 5'b01000,
    S_DUMP     = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and datapath commands.
  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    ctrl.load_in   = 1'b0;
    ctrl.scan_clr  = 1'b0;
    ctrl.scan_inc  = 1'b0;
    ctrl.srch_step = 1'b0;
    ctrl.emit      = EMIT_NONE;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load_in = 1'b1;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.cmd)
          CMD_APPEND: begin
            if (stat.out_free) begin
              ctrl.emit  = EMIT_APPEND;
              state_next = S_IDLE;
            end
          end
          CMD_DELETE: begin
            if (!stat.cnt_zero) begin
              ctrl.scan_clr = 1'b1;
              state_next    = S_SEARCH;
            end else if (stat.out_free) begin
              ctrl.emit  = EMIT_DELETE;
              state_next = S_IDLE;
            end
          end
          CMD_DUMP: begin
            if (!stat.cnt_zero) begin
              ctrl.scan_clr = 1'b1;
              state_next    = S_DUMP;
            end else if (stat.out_free) begin
              ctrl.emit  = EMIT_DUMP;
              state_next = S_IDLE;
            end
          end
          default: begin
            // Unused command code: dropped without a result.
            state_next = S_IDLE;
          end
        endcase
      end
      S_SEARCH: begin
        ctrl.srch_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DEL_DONE;
        end else begin
          ctrl.scan_inc = 1'b1;
        end
      end
      S_DEL_DONE: begin
        if (stat.out_free) begin
          ctrl.emit  = EMIT_DELETE;
          state_next = S_IDLE;
        end
      end
      S_DUMP: begin
        if (stat.out_free) begin
          ctrl.emit = EMIT_DUMP;
          if (stat.scan_last) begin
            state_next = S_IDLE;
          end else begin
            ctrl.scan_inc = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/ordered_value_list.sv
// ----------------------------------------------------------------------------
// ordered_value_list
// Append: the command is captured, then the result is loaded into the output
// register. Delete: one search step per cycle over the N stored entries, then
// the result; an empty list gives its result without a search. Dump: one
// result per stored entry, one per cycle while results are taken, or a single
// result with empty status on an empty list. A held result stalls the next.
// Reset clears the list to empty; entry storage is not cleared.
// ----------------------------------------------------------------------------
module ordered_value_list #(
  parameter int DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ovl_pkg::DATA_W-1:0]      s_tdata,  // [31:0] value
  input  logic [ovl_pkg::CMD_W-1:0]       s_tuser,  // [1:0] command
  // Result stream.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [31:0] item_value, [36:32] position, [38:37] status, [39] zero
  output logic [ovl_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                            m_tlast
);
  import ovl_pkg::*;

  ovl_ctrl_t         ctrl;
  ovl_stat_t         stat;
  logic [DATA_W-1:0] out_value;
  logic [POS_W-1:0]  out_pos;
  logic [ST_W-1:0]   out_status;

  ovl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  ovl_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .stat       (stat),
    .in_cmd     (s_tuser),
    .in_value   (s_tdata),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_value  (out_value),
    .out_pos    (out_pos),
    .out_status (out_status),
    .out_last   (m_tlast)
  );

  // Pack the result fields, lowest field first.
  assign m_tdata = OUT_TDATA_W'({out_status, out_pos, out_value});

endmodule
